@@ src/rrg_pkg.sv @@
// Shared types, constants and register codes for the reveal ramp glyph blend pipeline.
package rrg_pkg;

  localparam int COORD_BITS = 13;
  localparam int UC_BITS    = COORD_BITS - 1;
  localparam int DIV_BITS   = 8;
  localparam int STEP_IDX_W = $clog2(DIV_BITS);
  localparam int DVS_W      = 13;
  localparam int REM_W      = DVS_W + DIV_BITS - 1;
  localparam int N_W        = 11;
  localparam int ADDR_W     = 28;
  localparam int LANES      = 6;
  localparam int TEXT_LANES = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REVEAL_EDGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COLOR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_COLOR  = 3'd7;

  localparam logic [1:0] DEPTH_16   = 2'd0;
  localparam logic [1:0] DEPTH_24   = 2'd1;
  localparam logic [1:0] DEPTH_32   = 2'd2;
  localparam logic [1:0] DEPTH_NONE = 2'd3;

  localparam logic [7:0] BG_BASE [TEXT_LANES] = '{8'd12, 8'd15, 8'd18};
  localparam logic [2:0] BG_DROP [TEXT_LANES] = '{3'd3, 3'd4, 3'd5};

  typedef struct packed {
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic [15:0]        line_pitch;
    logic [28:0]        pixel_format;
    logic signed [13:0] reveal_edge;
    logic [9:0]         ramp_width;
    logic [23:0]        dim_color;
    logic [23:0]        bright_color;
  } cfg_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                         valid;
    logic [7:0]                   cov;
    logic [TEXT_LANES-1:0]        neg;
    logic [ADDR_W-1:0]            addr;
    lane_t [LANES-1:0]            lanes;
  } pipe_t;

  // Bytes per pixel for a depth code
  function automatic logic [2:0] depth_bytes(input logic [1:0] depth);
    return 3'(depth) + 3'd2;
  endfunction

endpackage

@@ src/reveal_ramp_glyph_pixel_blend_core.sv @@
// Top level of the reveal ramp glyph pixel blend pipeline with its configuration registers.
// One request per cycle; each accepted request comes back with its own result strobe.
// Depth is set by the 8 pipelined restoring division steps that share one stage per
// quotient bit across the text and background lanes, plus front and back stages.
// busy stays low: a request may start in every cycle and results cannot be held off.
// Synchronous reset clears all valid bits and loads the register defaults.
module reveal_ramp_glyph_pixel_blend_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rrg_pkg::COORD_BITS-1:0] pixel_x,
  input  logic signed [rrg_pkg::COORD_BITS-1:0] pixel_y,
  input  logic [7:0]                           coverage,
  output logic                                 result_valid,
  output logic [rrg_pkg::ADDR_W-1:0]           byte_address,
  output logic [31:0]                          pixel_word,
  output logic [2:0]                           byte_count,
  input  logic                                 cfg_we,
  input  logic [rrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rrg_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rrg_pkg::*;

  cfg_t             cfg;
  logic [DVS_W-1:0] dt;
  logic [DVS_W-1:0] db;
  pipe_t            stage [DIV_BITS + 1];

  assign busy = 1'b0;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd640;
      cfg.screen_height <= 13'd480;
      cfg.line_pitch    <= 16'd2560;
      cfg.pixel_format  <= 29'h1008_4442;
      cfg.reveal_edge   <= 14'sd0;
      cfg.ramp_width    <= 10'd1;
      cfg.dim_color     <= 24'h333B40;
      cfg.bright_color  <= 24'hEAF0F0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[12:0];
        REG_LINE_PITCH:    cfg.line_pitch    <= cfg_data[15:0];
        REG_PIXEL_FORMAT:  cfg.pixel_format  <= cfg_data[28:0];
        REG_REVEAL_EDGE:   cfg.reveal_edge   <= cfg_data[13:0];
        REG_RAMP_WIDTH:    cfg.ramp_width    <= cfg_data[9:0];
        REG_DIM_COLOR:     cfg.dim_color     <= cfg_data[23:0];
        REG_BRIGHT_COLOR:  cfg.bright_color  <= cfg_data[23:0];
        default:           cfg.screen_width  <= cfg.screen_width;
      endcase
    end
  end

  // Divisors: twice the ramp (one for a hard edge), and height minus one
  always_comb begin
    dt = (cfg.ramp_width == 10'd0) ? DVS_W'(1) : DVS_W'({cfg.ramp_width, 1'b0});
    db = (cfg.screen_height <= 13'd1) ? DVS_W'(1) : cfg.screen_height - 13'd1;
  end

  rrg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (start && !busy),
    .px       (pixel_x),
    .py       (pixel_y),
    .cov      (coverage),
    .cfg      (cfg),
    .pipe_out (stage[0])
  );

  // One stage per quotient bit, most significant first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    rrg_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .bit_idx  (STEP_IDX_W'(DIV_BITS - 1 - k)),
      .dt       (dt),
      .db       (db),
      .pipe_in  (stage[k]),
      .pipe_out (stage[k + 1])
    );
  end

  rrg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pipe_in      (stage[DIV_BITS]),
    .cfg          (cfg),
    .result_valid (result_valid),
    .byte_address (byte_address),
    .pixel_word   (pixel_word),
    .byte_count   (byte_count)
  );

endmodule

@@ src/rrg_front.sv @@
// Front stages: bounds check, reveal numerator, products and row address.
module rrg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req,
  input  logic signed [rrg_pkg::COORD_BITS-1:0] px,
  input  logic signed [rrg_pkg::COORD_BITS-1:0] py,
  input  logic [7:0]                          cov,
  input  rrg_pkg::cfg_t                       cfg,
  output rrg_pkg::pipe_t                      pipe_out
);
  import rrg_pkg::*;

  localparam int NW = 20;

  logic [UC_BITS-1:0]  ux;
  logic [UC_BITS-1:0]  uy;
  logic                in_x;
  logic                in_y;
  logic                ok;
  logic signed [NW-1:0] diff;
  logic signed [NW-1:0] nraw;
  logic [NW-1:0]       ramp2;
  logic [N_W-1:0]      n_next;

  logic                v1;
  logic [UC_BITS-1:0]  ux1;
  logic [UC_BITS-1:0]  uy1;
  logic [7:0]          cov1;
  logic [N_W-1:0]      n1;
  logic [ADDR_W-1:0]   yp1;

  pipe_t               nxt;
  logic [7:0]          dm;
  logic [7:0]          br;

  // Check visibility and form the clamped ramp numerator
  always_comb begin
    ux    = px[UC_BITS-1:0];
    uy    = py[UC_BITS-1:0];
    in_x  = !px[COORD_BITS-1] && (16'(ux) < 16'(cfg.screen_width));
    in_y  = !py[COORD_BITS-1] && (16'(uy) < 16'(cfg.screen_height));
    ok    = req && (cov != 8'd0) && in_x && in_y && (cfg.pixel_format[1:0] != DEPTH_NONE);
    diff  = NW'(cfg.reveal_edge) - NW'(px);
    ramp2 = NW'({cfg.ramp_width, 1'b0});
    nraw  = (diff <<< 1) + NW'(cfg.ramp_width);
    if (cfg.ramp_width == 10'd0) begin
      n_next = N_W'(!diff[NW-1]);
    end else if (nraw[NW-1]) begin
      n_next = '0;
    end else if (nraw > ramp2) begin
      n_next = ramp2[N_W-1:0];
    end else begin
      n_next = nraw[N_W-1:0];
    end
  end

  // Stage one: hold coordinates, numerator and row offset
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ok;
    end
    ux1  <= ux;
    uy1  <= uy;
    cov1 <= cov;
    n1   <= n_next;
    yp1  <= ADDR_W'(uy * cfg.line_pitch);
  end

  // Form dividends for the text and background lanes
  always_comb begin
    nxt       = '0;
    dm        = '0;
    br        = '0;
    nxt.valid = v1;
    nxt.cov   = cov1;
    nxt.addr  = yp1 + ADDR_W'(ux1 * depth_bytes(cfg.pixel_format[1:0]));
    for (int i = 0; i < TEXT_LANES; i++) begin
      dm = cfg.dim_color[16 - 8 * i +: 8];
      br = cfg.bright_color[16 - 8 * i +: 8];
      nxt.neg[i] = br < dm;
      nxt.lanes[i].rem = REM_W'(n1 * (nxt.neg[i] ? (dm - br) : (br - dm)));
      if (cfg.screen_height <= 13'd1) begin
        nxt.lanes[TEXT_LANES + i].rem = '0;
      end else begin
        nxt.lanes[TEXT_LANES + i].rem = REM_W'(BG_DROP[i] * uy1)
                                        + REM_W'(cfg.screen_height) - REM_W'(2);
      end
    end
  end

  // Stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_out <= '0;
    end else begin
      pipe_out <= nxt;
    end
  end

endmodule

@@ src/rrg_div_step.sv @@
// One restoring division step applied to every lane of the pipeline.
module rrg_div_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rrg_pkg::STEP_IDX_W-1:0]   bit_idx,
  input  logic [rrg_pkg::DVS_W-1:0]        dt,
  input  logic [rrg_pkg::DVS_W-1:0]        db,
  input  rrg_pkg::pipe_t                   pipe_in,
  output rrg_pkg::pipe_t                   pipe_out
);
  import rrg_pkg::*;

  pipe_t            nxt;
  logic [REM_W-1:0] cmp;
  logic             ge;

  // Subtract the shifted divisor where it fits and set the quotient bit
  always_comb begin
    nxt = pipe_in;
    cmp = '0;
    ge  = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      cmp = (l < TEXT_LANES) ? (REM_W'(dt) << bit_idx) : (REM_W'(db) << bit_idx);
      ge  = pipe_in.lanes[l].rem >= cmp;
      if (ge) begin
        nxt.lanes[l].rem = pipe_in.lanes[l].rem - cmp;
      end
      nxt.lanes[l].quo[bit_idx] = ge;
    end
  end

  // Advance one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_out <= '0;
    end else begin
      pipe_out <= nxt;
    end
  end

endmodule

@@ src/rrg_back.sv @@
// Back stages: channel colors, coverage blend, divide by 255 and pixel packing.
module rrg_back (
  input  logic                           clk,
  input  logic                           rst,
  input  rrg_pkg::pipe_t                 pipe_in,
  input  rrg_pkg::cfg_t                  cfg,
  output logic                           result_valid,
  output logic [rrg_pkg::ADDR_W-1:0]     byte_address,
  output logic [31:0]                    pixel_word,
  output logic [2:0]                     byte_count
);
  import rrg_pkg::*;

  logic [7:0]        text_next [TEXT_LANES];
  logic [9:0]        tsum;
  logic [7:0]        res_next [TEXT_LANES];
  logic [16:0]       q17;
  logic [31:0]       word_next;
  logic [38:0]       part;
  logic [4:0]        off;
  logic [3:0]        len;
  logic [2:0]        bpp;

  logic              v11, v12, v13;
  logic [7:0]        cov11;
  logic [ADDR_W-1:0] addr11, addr12, addr13;
  logic [7:0]        text11 [TEXT_LANES];
  logic [7:0]        bg11 [TEXT_LANES];
  logic [15:0]       mix12 [TEXT_LANES];
  logic [7:0]        res13 [TEXT_LANES];

  // Rebuild text channels from quotients
  always_comb begin
    tsum = '0;
    for (int i = 0; i < TEXT_LANES; i++) begin
      tsum = {2'b00, cfg.dim_color[16 - 8 * i +: 8]}
             + (pipe_in.neg[i] ? -{2'b00, pipe_in.lanes[i].quo}
                               : {2'b00, pipe_in.lanes[i].quo});
      text_next[i] = tsum[7:0];
    end
  end

  // Stage: text and background colors
  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= pipe_in.valid;
    end
    cov11  <= pipe_in.cov;
    addr11 <= pipe_in.addr;
    for (int i = 0; i < TEXT_LANES; i++) begin
      text11[i] <= text_next[i];
      bg11[i]   <= BG_BASE[i] - pipe_in.lanes[TEXT_LANES + i].quo;
    end
  end

  // Stage: weighted sum of text and background
  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
    addr12 <= addr11;
    for (int i = 0; i < TEXT_LANES; i++) begin
      mix12[i] <= 16'(text11[i] * cov11) + 16'(bg11[i] * (8'd255 - cov11));
    end
  end

  // Divide by 255 through the add-and-shift identity
  always_comb begin
    q17 = '0;
    for (int i = 0; i < TEXT_LANES; i++) begin
      q17 = (17'(mix12[i]) + 17'd1 + 17'(mix12[i] >> 8)) >> 8;
      res_next[i] = q17[7:0];
    end
  end

  // Stage: blended channels
  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= v12;
    end
    addr13 <= addr12;
    for (int i = 0; i < TEXT_LANES; i++) begin
      res13[i] <= res_next[i];
    end
  end

  // Pack channels into the configured layout and mask to the pixel size
  always_comb begin
    word_next = '0;
    part      = '0;
    off       = '0;
    len       = '0;
    bpp       = depth_bytes(cfg.pixel_format[1:0]);
    for (int i = 0; i < TEXT_LANES; i++) begin
      off = cfg.pixel_format[2 + 9 * i +: 5];
      len = cfg.pixel_format[7 + 9 * i +: 4];
      if (len > 4'd8) begin
        len = 4'd8;
      end
      if (len == 4'd0) begin
        part = '0;
      end else begin
        part = 39'(res13[i] >> (4'd8 - len)) << off;
      end
      word_next = word_next | part[31:0];
    end
    case (cfg.pixel_format[1:0])
      DEPTH_16: word_next = word_next & 32'h0000_FFFF;
      DEPTH_24: word_next = word_next & 32'h00FF_FFFF;
      default:  word_next = word_next;
    endcase
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v13;
    end
    byte_address <= addr13;
    pixel_word   <= word_next;
    byte_count   <= bpp;
  end

endmodule
